// ===== rtl/rpb_pkg.sv =====
// Shared types, constants and helper functions for the rotated pixel buffer.
// No dependencies; every rpb module imports this package.
package rpb_pkg;

  localparam int unsigned MaxDim  = 128;
  localparam int unsigned CoordW  = $clog2(MaxDim);
  localparam int unsigned DimW    = 8;
  localparam int unsigned AddrW   = 2 * CoordW;
  localparam int unsigned Depth   = MaxDim * MaxDim;
  localparam int unsigned PixW    = 32;
  localparam int unsigned MaxBpp  = 4;
  localparam int unsigned BppW    = 3;
  localparam int unsigned RotW    = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] RegImageWidth   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegRotation     = 2'd2;
  localparam logic [CfgIdxW-1:0] RegBytesPerPix  = 2'd3;

  localparam logic [RotW-1:0] Rot0   = 2'd0;
  localparam logic [RotW-1:0] Rot90  = 2'd1;
  localparam logic [RotW-1:0] Rot180 = 2'd2;
  localparam logic [RotW-1:0] Rot270 = 2'd3;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdRead  = 1'b1;

  // decoded word handed from the address stage to the memory stage and on
  typedef struct packed {
    logic             is_read;
    logic             err;
    logic [AddrW-1:0] addr;
    logic [PixW-1:0]  wdata;
    logic [PixW-1:0]  mask;
    logic [DimW-1:0]  rot_w;
    logic [DimW-1:0]  rot_h;
  } dec_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] d);
    return (d > DimW'(MaxDim)) ? DimW'(MaxDim) : d;
  endfunction

  // byte lane enables, saturating at MaxBpp and at the word width
  function automatic logic [PixW-1:0] pixel_mask(input logic [BppW-1:0] bpp);
    logic [BppW-1:0] b;
    logic [PixW-1:0] m;
    b = (bpp > BppW'(MaxBpp)) ? BppW'(MaxBpp) : bpp;
    for (int i = 0; i < PixW / 8; i++) begin
      m[i*8 +: 8] = {8{int'(b) > i}};
    end
    return m;
  endfunction

endpackage

// ===== rtl/rpb_decode.sv =====
// Address stage: bounds check, rotated-to-original coordinate mapping, masks.
// Depends on rpb_pkg.
module rpb_decode (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic                       command_i,
  input  logic [rpb_pkg::CoordW-1:0] row_i,
  input  logic [rpb_pkg::CoordW-1:0] column_i,
  input  logic [rpb_pkg::PixW-1:0]   pixel_in_i,
  input  logic [rpb_pkg::DimW-1:0]   image_width_i,
  input  logic [rpb_pkg::DimW-1:0]   image_height_i,
  input  logic [rpb_pkg::RotW-1:0]   rotation_i,
  input  logic [rpb_pkg::BppW-1:0]   bytes_per_pixel_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output rpb_pkg::dec_t              dec_o
);
  import rpb_pkg::*;

  logic [DimW-1:0] w, h, rw, rh, r8, c8, sr, sc;
  logic            swap, en;
  dec_t            dec_d, dec_q;
  logic            valid_q;

  always_comb begin
    w    = clamp_dim(image_width_i);
    h    = clamp_dim(image_height_i);
    swap = (rotation_i == Rot90) || (rotation_i == Rot270);
    rw   = swap ? h : w;
    rh   = swap ? w : h;
    r8   = {1'b0, row_i};
    c8   = {1'b0, column_i};
    case (rotation_i)
      Rot90: begin
        sr = c8;
        sc = w - 8'd1 - r8;
      end
      Rot180: begin
        sr = h - 8'd1 - r8;
        sc = w - 8'd1 - c8;
      end
      Rot270: begin
        sr = h - 8'd1 - c8;
        sc = r8;
      end
      default: begin
        sr = r8;
        sc = c8;
      end
    endcase
    dec_d.is_read = (command_i == CmdRead);
    if (command_i == CmdRead) begin
      dec_d.err  = !((r8 < rh) && (c8 < rw));
      dec_d.addr = {sr[CoordW-1:0], sc[CoordW-1:0]};
    end else begin
      dec_d.err  = !((r8 < h) && (c8 < w));
      dec_d.addr = {row_i, column_i};
    end
    dec_d.mask  = pixel_mask(bytes_per_pixel_i);
    dec_d.wdata = pixel_in_i & dec_d.mask;
    dec_d.rot_w = rw;
    dec_d.rot_h = rh;
  end

  assign en      = !valid_q || ready_i;
  assign ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      dec_q <= dec_d;
    end
  end

  assign valid_o = valid_q;
  assign dec_o   = dec_q;

endmodule

// ===== rtl/rpb_store.sv =====
// Memory stage: single-port pixel store, one write or one registered read per word.
// Depends on rpb_pkg.
module rpb_store (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  rpb_pkg::dec_t            dec_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output rpb_pkg::dec_t            dec_o,
  output logic [rpb_pkg::PixW-1:0] rdata_o
);
  import rpb_pkg::*;

  logic [PixW-1:0] mem [Depth];
  logic [PixW-1:0] rdata_q;
  dec_t            dec_q;
  logic            valid_q, en;

  assign en      = !valid_q || ready_i;
  assign ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  // read data only moves when the stage advances, so a stall holds it
  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      if (!dec_i.is_read && !dec_i.err) begin
        mem[dec_i.addr] <= dec_i.wdata;
      end
      rdata_q <= mem[dec_i.addr];
      dec_q   <= dec_i;
    end
  end

  assign valid_o = valid_q;
  assign dec_o   = dec_q;
  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rotated_pixel_buffer.sv =====
// Top level of the rotated pixel buffer: config registers, pipeline and output register.
// Depends on rpb_pkg, rpb_decode, rpb_store.

// Pixel store of 128 x 128 words of 32 bits, written in the original orientation
// and read back rotated by 0, 90, 180 or 270 degrees. Every input word (write or
// read) gives exactly one result word, in order, with status, masked pixel data
// and the rotated dimensions. Throughput is one word per clock while the output
// is not stalled. There are three register stages, passed in order (address
// stage, registered memory read, output register), and a stalled output holds
// every stage in place without losing a word. The store is one single-port
// memory doing one access per cycle. It is not cleared at reset: reading a
// pixel never written returns undefined data. Configuration registers may be
// changed only while the pipeline is empty.
module rotated_pixel_buffer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rpb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rpb_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         command_i,
  input  logic [rpb_pkg::CoordW-1:0]   row_i,
  input  logic [rpb_pkg::CoordW-1:0]   column_i,
  input  logic [rpb_pkg::PixW-1:0]     pixel_in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [rpb_pkg::PixW-1:0]     pixel_out_o,
  output logic                         status_o,
  output logic [rpb_pkg::DimW-1:0]     rotated_width_o,
  output logic [rpb_pkg::DimW-1:0]     rotated_height_o
);
  import rpb_pkg::*;

  logic [DimW-1:0] image_width_q, image_height_q;
  logic [RotW-1:0] rotation_q;
  logic [BppW-1:0] bpp_q;

  logic            dec_valid, dec_ready, mem_valid, mem_ready, out_en, out_valid_q;
  dec_t            dec, mem_dec;
  logic [PixW-1:0] rdata;
  logic [PixW-1:0] pixel_out_q;
  logic            status_q;
  logic [DimW-1:0] rot_w_q, rot_h_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= DimW'(MaxDim);
      image_height_q <= DimW'(MaxDim);
      rotation_q     <= Rot0;
      bpp_q          <= BppW'(MaxBpp);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegImageWidth:  image_width_q  <= cfg_data_i[DimW-1:0];
        RegImageHeight: image_height_q <= cfg_data_i[DimW-1:0];
        RegRotation:    rotation_q     <= cfg_data_i[RotW-1:0];
        RegBytesPerPix: bpp_q          <= cfg_data_i[BppW-1:0];
        default: ;
      endcase
    end
  end

  rpb_decode u_decode (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (in_valid_i),
    .ready_o           (in_ready_o),
    .command_i         (command_i),
    .row_i             (row_i),
    .column_i          (column_i),
    .pixel_in_i        (pixel_in_i),
    .image_width_i     (image_width_q),
    .image_height_i    (image_height_q),
    .rotation_i        (rotation_q),
    .bytes_per_pixel_i (bpp_q),
    .valid_o           (dec_valid),
    .ready_i           (dec_ready),
    .dec_o             (dec)
  );

  rpb_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .ready_o (dec_ready),
    .dec_i   (dec),
    .valid_o (mem_valid),
    .ready_i (mem_ready),
    .dec_o   (mem_dec),
    .rdata_o (rdata)
  );

  assign out_en    = !out_valid_q || out_ready_i;
  assign mem_ready = out_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= mem_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && mem_valid) begin
      pixel_out_q <= (mem_dec.is_read && !mem_dec.err) ? (rdata & mem_dec.mask) : '0;
      status_q    <= mem_dec.err;
      rot_w_q     <= mem_dec.rot_w;
      rot_h_q     <= mem_dec.rot_h;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign pixel_out_o      = pixel_out_q;
  assign status_o         = status_q;
  assign rotated_width_o  = rot_w_q;
  assign rotated_height_o = rot_h_q;

endmodule

// ===== rtl/rpb_checker.sv =====
// Port-level checks for the rotated pixel buffer, bound to the top level.
// Depends on rpb_pkg and rotated_pixel_buffer.
module rpb_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [rpb_pkg::PixW-1:0] pixel_out_o,
  input logic                     status_o,
  input logic [rpb_pkg::DimW-1:0] rotated_width_o,
  input logic [rpb_pkg::DimW-1:0] rotated_height_o
);
  import rpb_pkg::*;

  // no word may come out of reset
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  // an error word never carries pixel data
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (pixel_out_o == '0))
    else $error("error word with nonzero pixel data");

  // reported dimensions are clamped to the store size
  a_dim_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((rotated_width_o <= DimW'(MaxDim)) &&
                     (rotated_height_o <= DimW'(MaxDim))))
    else $error("rotated dimension above store size");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(pixel_out_o) &&
                                       $stable(status_o)))
    else $error("stalled output word changed");

endmodule

bind rotated_pixel_buffer rpb_checker u_rpb_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .pixel_out_o      (pixel_out_o),
  .status_o         (status_o),
  .rotated_width_o  (rotated_width_o),
  .rotated_height_o (rotated_height_o)
);

// ===== dv/rotated_pixel_buffer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for rotated_pixel_buffer: a directed table, then random pixel
// traffic under several frame settings, each result word checked against table or predictor.
// Depends on rpb_pkg and the rotated_pixel_buffer RTL.
module rotated_pixel_buffer_tb;
  import rpb_pkg::*;

  localparam logic        StatusOk   = 1'b0;
  localparam logic        StatusOob  = 1'b1;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned NumSteps   = 34;
  localparam int unsigned NumPhases  = 8;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            status;
    logic [DimW-1:0] rot_w;
    logic [DimW-1:0] rot_h;
  } pix_result_t;

  typedef enum logic {StepWord, StepReg} step_kind_e;

  typedef struct packed {
    step_kind_e           kind;
    logic                 cmd;
    logic [CoordW-1:0]    row;
    logic [CoordW-1:0]    column;
    logic [PixW-1:0]      pixel;
    logic [CfgIdxW-1:0]   reg_index;
    logic [CfgDataW-1:0]  reg_data;
    logic                 typed;
    pix_result_t          result;
  } dir_step_t;

  localparam pix_result_t NoCheck = '0;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                command_i;
  logic [CoordW-1:0]   row_i;
  logic [CoordW-1:0]   column_i;
  logic [PixW-1:0]     pixel_in_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [PixW-1:0]     pixel_out_o;
  logic                status_o;
  logic [DimW-1:0]     rotated_width_o;
  logic [DimW-1:0]     rotated_height_o;

  // predictor state
  logic [DimW-1:0]     cfg_width  = 8'd128;
  logic [DimW-1:0]     cfg_height = 8'd128;
  logic [RotW-1:0]     cfg_rot    = Rot0;
  logic [BppW-1:0]     cfg_bpp    = 3'd4;
  logic [PixW-1:0]     shadow_pixels [Depth];
  bit                  pixel_written [Depth];
  int unsigned         written_addrs [$];
  pix_result_t         pending_results [$];

  int unsigned         mismatches = 0;
  int unsigned         burst_left = 0;
  bit                  hold_req   = 1'b0;

  dir_step_t directed_steps [NumSteps] = '{
    '{StepWord, CmdWrite, 7'd0,   7'd0,   32'hFFFF_FFFF, RegImageWidth, 8'd0, 1'b1,
      '{32'h0, StatusOk, 8'd128, 8'd128}},
    '{StepWord, CmdWrite, 7'd127, 7'd127, 32'hA5A5_5A5A, RegImageWidth, 8'd0, 1'b1,
      '{32'h0, StatusOk, 8'd128, 8'd128}},
    '{StepWord, CmdWrite, 7'd0,   7'd127, 32'h1234_5678, RegImageWidth, 8'd0, 1'b1,
      '{32'h0, StatusOk, 8'd128, 8'd128}},
    '{StepWord, CmdWrite, 7'd127, 7'd0,   32'hDEAD_BEEF, RegImageWidth, 8'd0, 1'b1,
      '{32'h0, StatusOk, 8'd128, 8'd128}},
    '{StepWord, CmdRead,  7'd0,   7'd0,   32'h0, RegImageWidth, 8'd0, 1'b1,
      '{32'hFFFF_FFFF, StatusOk, 8'd128, 8'd128}},
    '{StepWord, CmdRead,  7'd127, 7'd127, 32'h0, RegImageWidth, 8'd0, 1'b1,
      '{32'hA5A5_5A5A, StatusOk, 8'd128, 8'd128}},
    '{StepReg,  CmdWrite, 7'd0,   7'd0,   32'h0, RegRotation, 8'(Rot90), 1'b0, NoCheck},
    '{StepWord, CmdRead,  7'd0,   7'd0,   32'h0, RegImageWidth, 8'd0, 1'b0, NoCheck},
    '{StepReg,  CmdWrite, 7'd0,   7'd0,   32'h0, RegRotation, 8'(Rot180), 1'b0, NoCheck},
    '{StepWord, CmdRead,  7'd0,   7'd0,   32'h0, RegImageWidth, 8'd0, 1'b0, NoCheck},
    '{StepReg,  CmdWrite, 7'd0,   7'd0,   32'h0, RegRotation, 8'(Rot270), 1'b0, NoCheck},
    '{StepWord, CmdRead,  7'd0,   7'd0,   32'h0, RegImageWidth, 8'd0, 1'b0, NoCheck},
    '{StepReg,  CmdWrite, 7'd0,   7'd0,   32'h0, RegBytesPerPix, 8'd1, 1'b0, NoCheck},
    '{StepWord, CmdRead,  7'd0,   7'd127, 32'h0, RegImageWidth, 8'd0, 1'b0, NoCheck},
    '{StepReg,  CmdWrite, 7'd0,   7'd0,   32'h0, RegBytesPerPix, 8'd0, 1'b0, NoCheck},
    '{StepWord, CmdRead,  7'd0,   7'd127, 32'h0, RegImageWidth, 8'd0, 1'b1,
      '{32'h0, StatusOk, 8'd128, 8'd128}},
    '{StepReg,  CmdWrite, 7'd0,   7'd0,   32'h0, RegBytesPerPix, 8'd7, 1'b0, NoCheck},
    '{StepWord, CmdRead,  7'd0,   7'd127, 32'h0, RegImageWidth, 8'd0, 1'b0, NoCheck},
    '{StepReg,  CmdWrite, 7'd0,   7'd0,   32'h0, RegImageWidth, 8'd255, 1'b0, NoCheck},
    '{StepReg,  CmdWrite, 7'd0,   7'd0,   32'h0, RegImageHeight, 8'd5, 1'b0, NoCheck},
    '{StepReg,  CmdWrite, 7'd0,   7'd0,   32'h0, RegRotation, 8'(Rot0), 1'b0, NoCheck},
    '{StepReg,  CmdWrite, 7'd0,   7'd0,   32'h0, RegBytesPerPix, 8'd3, 1'b0, NoCheck},
    '{StepWord, CmdWrite, 7'd4,   7'd127, 32'hFFFF_FFFF, RegImageWidth, 8'd0, 1'b1,
      '{32'h0, StatusOk, 8'd128, 8'd5}},
    '{StepWord, CmdWrite, 7'd5,   7'd0,   32'h0000_0001, RegImageWidth, 8'd0, 1'b1,
      '{32'h0, StatusOob, 8'd128, 8'd5}},
    '{StepWord, CmdRead,  7'd4,   7'd127, 32'h0, RegImageWidth, 8'd0, 1'b1,
      '{32'h00FF_FFFF, StatusOk, 8'd128, 8'd5}},
    '{StepWord, CmdRead,  7'd5,   7'd0,   32'h0, RegImageWidth, 8'd0, 1'b1,
      '{32'h0, StatusOob, 8'd128, 8'd5}},
    '{StepReg,  CmdWrite, 7'd0,   7'd0,   32'h0, RegRotation, 8'(Rot90), 1'b0, NoCheck},
    '{StepWord, CmdRead,  7'd0,   7'd4,   32'h0, RegImageWidth, 8'd0, 1'b0, NoCheck},
    '{StepWord, CmdRead,  7'd0,   7'd5,   32'h0, RegImageWidth, 8'd0, 1'b1,
      '{32'h0, StatusOob, 8'd5, 8'd128}},
    '{StepReg,  CmdWrite, 7'd0,   7'd0,   32'h0, RegImageWidth, 8'd0, 1'b0, NoCheck},
    '{StepWord, CmdWrite, 7'd0,   7'd0,   32'h5555_AAAA, RegImageWidth, 8'd0, 1'b0, NoCheck},
    '{StepWord, CmdRead,  7'd0,   7'd0,   32'h0, RegImageWidth, 8'd0, 1'b0, NoCheck},
    '{StepReg,  CmdWrite, 7'd0,   7'd0,   32'h0, RegImageHeight, 8'd0, 1'b0, NoCheck},
    '{StepWord, CmdWrite, 7'd127, 7'd127, 32'h0, RegImageWidth, 8'd0, 1'b0, NoCheck}
  };

  rotated_pixel_buffer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .row_i            (row_i),
    .column_i         (column_i),
    .pixel_in_i       (pixel_in_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .pixel_out_o      (pixel_out_o),
    .status_o         (status_o),
    .rotated_width_o  (rotated_width_o),
    .rotated_height_o (rotated_height_o)
  );

  function automatic int unsigned clamp_size(logic [DimW-1:0] d);
    return (d > MaxDim) ? MaxDim : int'(d);
  endfunction

  function automatic bit axes_swapped();
    return (cfg_rot == Rot90) || (cfg_rot == Rot270);
  endfunction

  function automatic bit in_rotated_frame(logic [CoordW-1:0] r, logic [CoordW-1:0] c);
    int unsigned w, h;
    w = clamp_size(cfg_width);
    h = clamp_size(cfg_height);
    return axes_swapped() ? (r < w && c < h) : (r < h && c < w);
  endfunction

  // rotated (r, c) back to the original store address; valid only inside the frame
  function automatic int unsigned source_addr(logic [CoordW-1:0] r, logic [CoordW-1:0] c);
    int unsigned w, h, sr, sc;
    w = clamp_size(cfg_width);
    h = clamp_size(cfg_height);
    case (cfg_rot)
      Rot90:   begin sr = c;         sc = w - 1 - r; end
      Rot180:  begin sr = h - 1 - r; sc = w - 1 - c; end
      Rot270:  begin sr = h - 1 - c; sc = r;         end
      default: begin sr = r;         sc = c;         end
    endcase
    return sr * MaxDim + sc;
  endfunction

  function automatic pix_result_t compute_pixel_result(logic cmd, logic [CoordW-1:0] r,
                                                       logic [CoordW-1:0] c,
                                                       logic [PixW-1:0] pix);
    pix_result_t res;
    int unsigned w, h, addr, nbytes;
    logic [PixW-1:0] lanes;
    w = clamp_size(cfg_width);
    h = clamp_size(cfg_height);
    nbytes = (cfg_bpp > MaxBpp) ? MaxBpp : int'(cfg_bpp);
    lanes = (nbytes >= 4) ? '1 : ((PixW'(1) << (8 * nbytes)) - 1);
    res = '0;
    res.rot_w = DimW'(axes_swapped() ? h : w);
    res.rot_h = DimW'(axes_swapped() ? w : h);
    if (cmd == CmdWrite) begin
      if (r < h && c < w) begin
        addr = r * MaxDim + c;
        shadow_pixels[addr] = pix & lanes;
        if (!pixel_written[addr]) begin
          pixel_written[addr] = 1'b1;
          written_addrs.push_back(addr);
        end
      end else begin
        res.status = StatusOob;
      end
    end else if (in_rotated_frame(r, c)) begin
      res.pixel = shadow_pixels[source_addr(r, c)] & lanes;
    end else begin
      res.status = StatusOob;
    end
    return res;
  endfunction

  // mostly reads of stored pixels and in-frame writes; the rest random coordinates
  task automatic choose_word(output logic cmd, output logic [CoordW-1:0] r,
                             output logic [CoordW-1:0] c);
    int unsigned roll, w, h, addr, sr, sc, tries;
    bit found;
    w = clamp_size(cfg_width);
    h = clamp_size(cfg_height);
    roll = $urandom_range(99);
    found = 1'b0;
    if (roll < 45 && written_addrs.size() > 0) begin
      for (tries = 0; tries < 8 && !found; tries++) begin
        addr = written_addrs[$urandom_range(written_addrs.size() - 1)];
        sr = addr / MaxDim;
        sc = addr % MaxDim;
        found = (sr < h) && (sc < w);
      end
      if (found) begin
        cmd = CmdRead;
        case (cfg_rot)
          Rot90:   begin r = CoordW'(w - 1 - sc); c = CoordW'(sr);         end
          Rot180:  begin r = CoordW'(h - 1 - sr); c = CoordW'(w - 1 - sc); end
          Rot270:  begin r = CoordW'(sc);         c = CoordW'(h - 1 - sr); end
          default: begin r = CoordW'(sr);         c = CoordW'(sc);         end
        endcase
        return;
      end
    end
    if (roll >= 85) begin
      r = CoordW'($urandom);
      c = CoordW'($urandom);
      // never read a store entry that holds no pixel yet
      if (!in_rotated_frame(r, c) || pixel_written[source_addr(r, c)]) begin
        cmd = CmdRead;
        return;
      end
    end
    cmd = CmdWrite;
    if (w > 0 && h > 0 && $urandom_range(9) != 0) begin
      r = CoordW'($urandom_range(h - 1));
      c = CoordW'($urandom_range(w - 1));
    end else begin
      r = CoordW'($urandom);
      c = CoordW'($urandom);
    end
  endtask

  task automatic offer_word(input logic cmd, input logic [CoordW-1:0] r,
                            input logic [CoordW-1:0] c, input logic [PixW-1:0] pix,
                            input bit typed, input pix_result_t given);
    pix_result_t res;
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      gap = $urandom_range(6);
      if (gap != 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    command_i  = cmd;
    row_i      = r;
    column_i   = c;
    pixel_in_i = pix;
    do @(posedge clk_i); while (!in_ready_o);
    res = compute_pixel_result(cmd, r, c, pix);
    pending_results.push_back(typed ? given : res);
  endtask

  // registers change only with the pipeline empty
  task automatic drain();
    if (in_valid_i) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegImageWidth:  cfg_width  = data;
      RegImageHeight: cfg_height = data;
      RegRotation:    cfg_rot    = data[RotW-1:0];
      RegBytesPerPix: cfg_bpp    = data[BppW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  // the receiver switches between random stall patterns, plus one long hold-off
  initial begin : receiver
    int unsigned mode, mode_left, hold_left;
    out_ready_i = 1'b0;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(3);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i = 1'b0;
      end else begin
        case (mode)
          0:       out_ready_i = 1'b1;
          1:       out_ready_i = 1'($urandom_range(1));
          2:       out_ready_i = ($urandom_range(3) == 0);
          default: out_ready_i = ($urandom_range(7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    pix_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing pending: pixel_out %h status %b", pixel_out_o,
               status_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (pixel_out_o !== want.pixel) begin
          $error("pixel_out: expected %h, got %h", want.pixel, pixel_out_o);
          mismatches++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %b, got %b", want.status, status_o);
          mismatches++;
        end
        if (rotated_width_o !== want.rot_w) begin
          $error("rotated_width: expected %0d, got %0d", want.rot_w, rotated_width_o);
          mismatches++;
        end
        if (rotated_height_o !== want.rot_h) begin
          $error("rotated_height: expected %0d, got %0d", want.rot_h, rotated_height_o);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    logic              cmd;
    logic [CoordW-1:0] r, c;
    logic [PixW-1:0]   pix;
    logic [DimW-1:0]   w, h;
    logic [RotW-1:0]   rot;
    logic [BppW-1:0]   bpp;
    int unsigned       n_words;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = RegImageWidth;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    command_i   = CmdWrite;
    row_i       = '0;
    column_i    = '0;
    pixel_in_i  = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == StepReg) begin
        drain();
        set_reg(directed_steps[i].reg_index, directed_steps[i].reg_data);
      end else begin
        offer_word(directed_steps[i].cmd, directed_steps[i].row, directed_steps[i].column,
                   directed_steps[i].pixel, directed_steps[i].typed,
                   directed_steps[i].result);
      end
    end

    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0:       begin w = 8'd128; h = 8'd128; rot = Rot0;   bpp = 3'd4; end
        1:       begin w = 8'd255; h = 8'd200; rot = Rot90;  bpp = 3'd7; end
        2:       begin w = 8'd1;   h = 8'd1;   rot = Rot180; bpp = 3'd2; end
        3:       begin w = 8'd0;   h = DimW'($urandom_range(1, 128)); rot = Rot270; bpp = 3'd1;
                 end
        default: begin
          w   = DimW'(($urandom_range(3) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 16));
          h   = DimW'(($urandom_range(3) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 16));
          rot = RotW'($urandom);
          bpp = BppW'($urandom);
        end
      endcase
      drain();
      set_reg(RegImageWidth, w);
      set_reg(RegImageHeight, h);
      // upper data bits are don't-care for the narrow registers
      set_reg(RegRotation, {6'($urandom), rot});
      set_reg(RegBytesPerPix, {5'($urandom), bpp});
      n_words = (phase == 3) ? 30 : 140;
      for (int k = 0; k < n_words; k++) begin
        if (phase == 5 && k == 40) hold_req = 1'b1;
        choose_word(cmd, r, c);
        case ($urandom_range(15))
          0:       pix = '0;
          1:       pix = '1;
          default: pix = $urandom;
        endcase
        offer_word(cmd, r, c, pix, 1'b0, NoCheck);
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
